@@ hw/rtl/mfsf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfsf_pkg
// Shared constants and types for the market feed symbol filter.
// ----------------------------------------------------------------------------
package mfsf_pkg;

  localparam int MAX_SYMBOLS   = 4;
  localparam int SYMBOL_REGS   = 4;
  localparam int DIRECTORY_LEN = 39;
  localparam int LOCATE_SPACE  = 65536;

  localparam int SYM_IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int SYM_CNT_W = 3;
  localparam int LEN_W     = 8;
  localparam int TYPE_W    = 8;
  localparam int LOC_W     = 16;
  localparam int STOCK_W   = 64;
  localparam int COUNT_W   = 8;

  // Bitmap storage: rows of 64 marks each.
  localparam int SLOT_W    = $clog2(LOCATE_SPACE);
  localparam int ROW_W     = 64;
  localparam int ROW_BIT_W = $clog2(ROW_W);
  localparam int ROWS      = LOCATE_SPACE / ROW_W;
  localparam int ROW_AW    = $clog2(ROWS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_A     = 3'd1;

  localparam logic [LEN_W-1:0]   MIN_LEN        = 8'd11;
  localparam logic [LEN_W-1:0]   DIR_LEN        = LEN_W'(DIRECTORY_LEN);
  localparam logic [TYPE_W-1:0]  TYPE_SYSTEM    = 8'h53;
  localparam logic [TYPE_W-1:0]  TYPE_DIRECTORY = 8'h52;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

  typedef enum logic [1:0] {
    KIND_REJECT,
    KIND_PASS,
    KIND_LOOKUP,
    KIND_MATCH
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SYM_IDX_W-1:0] sym_idx;
    logic [LOC_W-1:0]     locate;
  } cls_req_t;

  typedef struct packed {
    logic               accept;
    logic               all_resolved;
    logic [COUNT_W-1:0] resolved_count;
    logic [LOC_W-1:0]   first_locate;
  } result_t;

  // Request queue status between the front and back parts.
  typedef struct packed {
    logic     empty;
    cls_req_t head;
  } req_link_t;

endpackage
`default_nettype wire

@@ hw/rtl/market_feed_symbol_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// market_feed_symbol_filter
// Stock locate filter for market feed message headers.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while full is low, and one result is
// produced for each, in order; a request passes through the front queue,
// where its bitmap row is read, then the execute stage, which writes its
// result into the result queue. The rate is set by the read-modify-write
// of the locate bitmap RAM, which forwards the most recently written row so
// back-to-back requests to the same row see each other's marks. After reset
// the bitmap is cleared one 64-bit row per cycle, all 1024 rows, and full
// stays high during that pass; configuration writes are taken at any time.
// Configuration must only be written while no request is in flight.
module market_feed_symbol_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [mfsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mfsf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [mfsf_pkg::LEN_W-1:0]        msg_length,
  input  wire logic [mfsf_pkg::TYPE_W-1:0]       msg_type,
  input  wire logic [mfsf_pkg::LOC_W-1:0]        stock_locate,
  input  wire logic [mfsf_pkg::STOCK_W-1:0]      stock_field,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   accept,
  output logic                                   all_resolved,
  output logic [mfsf_pkg::COUNT_W-1:0]           resolved_count,
  output logic [mfsf_pkg::LOC_W-1:0]             first_locate
);
  import mfsf_pkg::*;

  logic [SYM_CNT_W-1:0]                  symbol_count;
  logic [MAX_SYMBOLS-1:0][STOCK_W-1:0]   symbols;
  logic [SYM_CNT_W-1:0]                  eff_count;
  logic                                  front_full;
  logic                                  clearing;
  logic                                  req_pop;
  req_link_t                             req_link;
  result_t                               head;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      symbols      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SYMBOL_COUNT) begin
        symbol_count <= cfg_data[SYM_CNT_W-1:0];
      end
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        if ((i < SYMBOL_REGS) && (cfg_index == CFG_SYMBOL_A + CFG_IDX_W'(i))) begin
          symbols[i] <= cfg_data;
        end
      end
    end
  end

  assign eff_count = (symbol_count < SYM_CNT_W'(MAX_SYMBOLS)) ?
                     symbol_count : SYM_CNT_W'(MAX_SYMBOLS);

  assign full = front_full || clearing;

  mfsf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push && !clearing),
    .msg_length   (msg_length),
    .msg_type     (msg_type),
    .stock_locate (stock_locate),
    .stock_field  (stock_field),
    .symbols      (symbols),
    .eff_count    (eff_count),
    .full         (front_full),
    .req_pop      (req_pop),
    .req_link     (req_link)
  );

  mfsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_link  (req_link),
    .req_pop   (req_pop),
    .eff_count (eff_count),
    .clearing  (clearing),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  assign accept         = head.accept;
  assign all_resolved   = head.all_resolved;
  assign resolved_count = head.resolved_count;
  assign first_locate   = head.first_locate;

endmodule
`default_nettype wire

@@ hw/rtl/mfsf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/mfsf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfsf_front
// Classifies each message header and queues the request for the back part.
// ----------------------------------------------------------------------------
module mfsf_front (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        push,
  input  wire logic [mfsf_pkg::LEN_W-1:0]                  msg_length,
  input  wire logic [mfsf_pkg::TYPE_W-1:0]                 msg_type,
  input  wire logic [mfsf_pkg::LOC_W-1:0]                  stock_locate,
  input  wire logic [mfsf_pkg::STOCK_W-1:0]                stock_field,
  input  wire logic [mfsf_pkg::MAX_SYMBOLS-1:0][mfsf_pkg::STOCK_W-1:0] symbols,
  input  wire logic [mfsf_pkg::SYM_CNT_W-1:0]              eff_count,
  output logic                                             full,
  input  wire logic                                        req_pop,
  output mfsf_pkg::req_link_t                              req_link
);
  import mfsf_pkg::*;

  localparam int QDEPTH = 2;

  cls_req_t          q [QDEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        cnt;
  cls_req_t          cls;
  logic              hit;
  logic [SYM_IDX_W-1:0] hit_idx;
  logic              do_push;
  logic              do_pop;

  // First configured symbol that matches wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((SYM_CNT_W'(i) < eff_count) && (symbols[i] == stock_field)) begin
        hit     = 1'b1;
        hit_idx = SYM_IDX_W'(i);
      end
    end
  end

  always_comb begin
    cls.locate  = stock_locate;
    cls.sym_idx = hit_idx;
    if (msg_length < MIN_LEN) begin
      cls.kind = KIND_REJECT;
    end else if (msg_type == TYPE_SYSTEM) begin
      cls.kind = KIND_PASS;
    end else if (msg_type != TYPE_DIRECTORY) begin
      cls.kind = KIND_LOOKUP;
    end else if (msg_length < DIR_LEN) begin
      cls.kind = KIND_REJECT;
    end else if (hit) begin
      cls.kind = KIND_MATCH;
    end else begin
      cls.kind = KIND_REJECT;
    end
  end

  assign full          = (cnt == 2'(QDEPTH));
  assign do_push       = push && !full;
  assign do_pop        = req_pop && (cnt != 2'd0);
  assign req_link.empty = (cnt == 2'd0);
  assign req_link.head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mfsf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfsf_back
// Locate bitmap engine: read-modify-write of the mark rows, match counting,
// symbol locate records, the bitmap clearing pass and the result queue.
// ----------------------------------------------------------------------------
module mfsf_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  mfsf_pkg::req_link_t                   req_link,
  output logic                                  req_pop,
  input  wire logic [mfsf_pkg::SYM_CNT_W-1:0]   eff_count,
  output logic                                  clearing,
  input  wire logic                             pop,
  output logic                                  empty,
  output mfsf_pkg::result_t                     head
);
  import mfsf_pkg::*;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // Clearing pass state
  logic [ROW_AW-1:0]  clr_row;

  // Execute stage
  logic               e_valid;
  cls_req_t           e_req;
  logic               issue;

  // Bitmap port and forwarding of the latest written row
  logic [ROW_W-1:0]   ram_rdata;
  logic               ram_we;
  logic [ROW_AW-1:0]  ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  logic               fwd_valid;
  logic [ROW_AW-1:0]  fwd_row;
  logic [ROW_W-1:0]   fwd_data;
  logic [ROW_AW-1:0]  e_row;
  logic [ROW_W-1:0]   row_cur;
  logic [ROW_W-1:0]   row_set;
  logic               marked;
  logic               is_match;

  // Architectural state
  logic [COUNT_W-1:0] match_count;
  logic [COUNT_W-1:0] match_count_next;
  logic [LOC_W-1:0]   locates      [MAX_SYMBOLS];
  logic [LOC_W-1:0]   locates_next [MAX_SYMBOLS];
  result_t            res;

  // Result queue
  result_t            out_q [OUT_DEPTH];
  logic [OUT_AW-1:0]  out_wr;
  logic [OUT_AW-1:0]  out_rd;
  logic [OUT_CW-1:0]  out_count;
  logic               out_pop;

  // An item is issued only when the result queue has room for it and for
  // the one already in the execute stage.
  assign issue   = !req_link.empty && !clearing &&
                   ((out_count + OUT_CW'(e_valid)) < OUT_CW'(OUT_DEPTH));
  assign req_pop = issue;

  assign e_row    = e_req.locate[SLOT_W-1:ROW_BIT_W];
  assign row_cur  = (fwd_valid && (fwd_row == e_row)) ? fwd_data : ram_rdata;
  assign marked   = row_cur[e_req.locate[ROW_BIT_W-1:0]];
  assign row_set  = row_cur | (ROW_W'(1) << e_req.locate[ROW_BIT_W-1:0]);
  assign is_match = e_valid && (e_req.kind == KIND_MATCH);

  assign ram_we    = clearing || is_match;
  assign ram_waddr = clearing ? clr_row : e_row;
  assign ram_wdata = clearing ? '0 : row_set;

  mfsf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_marks (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (req_link.head.locate[SLOT_W-1:ROW_BIT_W]),
    .rd_data (ram_rdata)
  );

  always_comb begin
    match_count_next = match_count;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      locates_next[i] = locates[i];
    end
    if (is_match) begin
      if (!marked && (match_count != COUNT_MAX)) begin
        match_count_next = match_count + COUNT_W'(1);
      end
      locates_next[e_req.sym_idx] = e_req.locate;
    end
  end

  always_comb begin
    case (e_req.kind)
      KIND_REJECT: res.accept = 1'b0;
      KIND_PASS:   res.accept = 1'b1;
      KIND_LOOKUP: res.accept = marked;
      KIND_MATCH:  res.accept = 1'b1;
      default:     res.accept = 1'b0;
    endcase
    res.all_resolved   = (match_count_next == COUNT_W'(eff_count));
    res.resolved_count = match_count_next;
    res.first_locate   = (eff_count == '0) ? '0 : locates_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_row     <= '0;
      e_valid     <= 1'b0;
      fwd_valid   <= 1'b0;
      match_count <= '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        locates[i] <= '0;
      end
    end else begin
      if (clearing) begin
        clr_row <= clr_row + ROW_AW'(1);
        if (clr_row == ROW_AW'(ROWS - 1)) begin
          clearing <= 1'b0;
        end
      end
      e_valid     <= issue;
      match_count <= match_count_next;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        locates[i] <= locates_next[i];
      end
      if (is_match) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      e_req <= req_link.head;
    end
    if (is_match) begin
      fwd_row  <= e_row;
      fwd_data <= row_set;
    end
  end

  // Result queue
  assign empty   = (out_count == '0);
  assign out_pop = pop && !empty;
  assign head    = out_q[out_rd];

  always_ff @(posedge clk) begin
    if (e_valid) begin
      out_q[out_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (e_valid) begin
        out_wr <= out_wr + OUT_AW'(1);
      end
      if (out_pop) begin
        out_rd <= out_rd + OUT_AW'(1);
      end
      out_count <= out_count + OUT_CW'(e_valid) - OUT_CW'(out_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> (out_count < OUT_CW'(OUT_DEPTH)))
    else $error("result queue written while full");

  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!issue && !e_valid))
    else $error("request handled during bitmap clearing pass");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (match_count >= $past(match_count)))
    else $error("match count decreased");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !is_match |=> $stable(match_count))
    else $error("match count changed without a directory match");
`endif

endmodule
`default_nettype wire

@@ verif/tb_market_feed_symbol_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_market_feed_symbol_filter
// Self-checking bench for the market feed stock locate filter. A queue-fed
// driver offers message headers, a shadow of the locate bitmap, the symbol
// slots and the resolved count predicts each result, and a monitor compares
// every popped result field by field. The run steps through several symbol
// tables and idle patterns, with one long result stall and full drains.
// ----------------------------------------------------------------------------
module tb_market_feed_symbol_filter;
  import mfsf_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_B = CFG_SYMBOL_A + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_C = CFG_SYMBOL_A + 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_D = CFG_SYMBOL_A + 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_5  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7  = 3'd7;

  localparam logic [TYPE_W-1:0] TYPE_ADD_ORDER = 8'h41;
  localparam logic [TYPE_W-1:0] TYPE_LOW       = 8'h00;
  localparam logic [TYPE_W-1:0] TYPE_HIGH      = 8'hFF;

  localparam logic [STOCK_W-1:0] SYM_AAAA  = "AAAA    ";
  localparam logic [STOCK_W-1:0] SYM_BBBB  = "BBBB    ";
  localparam logic [STOCK_W-1:0] SYM_CCC   = "CCC     ";
  localparam logic [STOCK_W-1:0] SYM_DDDD  = "DDDD    ";
  localparam logic [STOCK_W-1:0] SYM_EEE   = "EEE     ";
  localparam logic [STOCK_W-1:0] SYM_FFF   = "FFF     ";
  localparam logic [STOCK_W-1:0] SYM_GGGGG = "GGGGG   ";
  localparam logic [STOCK_W-1:0] SYM_ONES  = '1;
  localparam logic [STOCK_W-1:0] SYM_ZERO  = '0;

  typedef struct packed {
    logic [LEN_W-1:0]   msg_len;
    logic [TYPE_W-1:0]  msg_kind;
    logic [LOC_W-1:0]   locate;
    logic [STOCK_W-1:0] stock;
  } feed_msg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [LEN_W-1:0]      msg_length = '0;
  logic [TYPE_W-1:0]     msg_type = '0;
  logic [LOC_W-1:0]      stock_locate = '0;
  logic [STOCK_W-1:0]    stock_field = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  accept;
  logic                  all_resolved;
  logic [COUNT_W-1:0]    resolved_count;
  logic [LOC_W-1:0]      first_locate;

  market_feed_symbol_filter u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .msg_length     (msg_length),
    .msg_type       (msg_type),
    .stock_locate   (stock_locate),
    .stock_field    (stock_field),
    .empty          (empty),
    .pop            (pop),
    .accept         (accept),
    .all_resolved   (all_resolved),
    .resolved_count (resolved_count),
    .first_locate   (first_locate)
  );

  always #10 clk = ~clk;

  // Shadow of the filter state.
  logic [SYM_CNT_W-1:0] symbol_count_q = '0;
  logic [STOCK_W-1:0]   symbol_q [MAX_SYMBOLS];
  logic [LOC_W-1:0]     symbol_locate_q [MAX_SYMBOLS];
  logic [COUNT_W-1:0]   match_count_q = '0;
  bit                   locate_marks [LOCATE_SPACE];

  feed_msg_t         pending_msgs [$];
  result_t           expected_results [$];
  logic [LOC_W-1:0]  used_locates [$];
  result_t           head_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;
  int fail_count    = 0;

  initial begin
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      symbol_q[i]        = '0;
      symbol_locate_q[i] = '0;
    end
  end

  function automatic result_t predict_filter(input feed_msg_t m);
    result_t res;
    logic    hit;
    int      n;
    int      slot;
    n    = (int'(symbol_count_q) < MAX_SYMBOLS) ? int'(symbol_count_q) : MAX_SYMBOLS;
    slot = int'(m.locate) % LOCATE_SPACE;
    hit  = 1'b0;
    if (m.msg_len < MIN_LEN) begin
      hit = 1'b0;
    end else if (m.msg_kind == TYPE_SYSTEM) begin
      hit = 1'b1;
    end else if (m.msg_kind != TYPE_DIRECTORY) begin
      hit = locate_marks[slot];
    end else if (m.msg_len >= DIR_LEN) begin
      // First configured symbol that matches wins.
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        if (!hit && i < n && symbol_q[i] == m.stock) begin
          hit = 1'b1;
          if (!locate_marks[slot] && match_count_q != COUNT_MAX) begin
            match_count_q = match_count_q + COUNT_W'(1);
          end
          symbol_locate_q[i] = m.locate;
          locate_marks[slot] = 1'b1;
        end
      end
    end
    res.accept         = hit;
    res.all_resolved   = (int'(match_count_q) == n);
    res.resolved_count = match_count_q;
    res.first_locate   = (n == 0) ? '0 : symbol_locate_q[0];
    return res;
  endfunction

  function automatic feed_msg_t random_msg();
    feed_msg_t m;
    int        pick;
    pick       = $urandom_range(99);
    m.msg_len  = LEN_W'($urandom_range(255));
    m.msg_kind = TYPE_W'($urandom_range(255));
    m.locate   = LOC_W'($urandom);
    m.stock    = {$urandom, $urandom};
    if (pick < 40) begin
      // Directory message naming one of the symbol registers.
      m.msg_kind = TYPE_DIRECTORY;
      m.msg_len  = ($urandom_range(9) == 0) ?
                   LEN_W'($urandom_range(int'(MIN_LEN), int'(DIR_LEN) - 1)) :
                   LEN_W'($urandom_range(int'(DIR_LEN), 255));
      m.stock    = symbol_q[$urandom_range(MAX_SYMBOLS - 1)];
      if (used_locates.size() != 0 && $urandom_range(3) == 0) begin
        m.locate = used_locates[$urandom_range(used_locates.size() - 1)];
      end else begin
        used_locates.push_back(m.locate);
      end
    end else if (pick < 75) begin
      // Order traffic, mostly against locates seen in the directory.
      m.msg_len = LEN_W'($urandom_range(int'(MIN_LEN), 255));
      if (m.msg_kind == TYPE_SYSTEM || m.msg_kind == TYPE_DIRECTORY) begin
        m.msg_kind = TYPE_ADD_ORDER;
      end
      if (used_locates.size() != 0 && $urandom_range(4) != 0) begin
        m.locate = used_locates[$urandom_range(used_locates.size() - 1)];
      end
    end else if (pick < 82) begin
      m.msg_kind = TYPE_SYSTEM;
    end else if (pick < 90) begin
      m.msg_kind = TYPE_DIRECTORY;
      m.msg_len  = LEN_W'($urandom_range(int'(DIR_LEN), 255));
    end
    return m;
  endfunction

  task automatic queue_msg(input logic [LEN_W-1:0] len, input logic [TYPE_W-1:0] kind,
                           input logic [LOC_W-1:0] loc, input logic [STOCK_W-1:0] stock);
    feed_msg_t m;
    m.msg_len  = len;
    m.msg_kind = kind;
    m.locate   = loc;
    m.stock    = stock;
    pending_msgs.push_back(m);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      pending_msgs.push_back(random_msg());
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SYMBOL_COUNT) begin
      symbol_count_q = data[SYM_CNT_W-1:0];
    end else if (idx >= CFG_SYMBOL_A && idx <= CFG_SYMBOL_D) begin
      symbol_q[idx - CFG_SYMBOL_A] = data;
    end
  endtask

  task automatic wait_drained();
    while (pending_msgs.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_symbols(input logic [SYM_CNT_W-1:0] count,
                              input logic [STOCK_W-1:0] a, input logic [STOCK_W-1:0] b,
                              input logic [STOCK_W-1:0] c, input logic [STOCK_W-1:0] d);
    write_reg(CFG_SYMBOL_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_SYMBOL_A, a);
    write_reg(CFG_SYMBOL_B, b);
    write_reg(CFG_SYMBOL_C, c);
    write_reg(CFG_SYMBOL_D, d);
  endtask

  // Driver: holds a request until taken, predicts it on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_filter(pending_msgs.pop_front()));
      end
      if (!(push && full)) begin
        if (pending_msgs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push         <= 1'b1;
          msg_length   <= pending_msgs[0].msg_len;
          msg_type     <= pending_msgs[0].msg_kind;
          stock_locate <= pending_msgs[0].locate;
          stock_field  <= pending_msgs[0].stock;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each popped result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result popped with no request outstanding");
          fail_count++;
        end else begin
          head_result = expected_results.pop_front();
          if (accept !== head_result.accept) begin
            $error("accept: expected %0d, got %0d", head_result.accept, accept);
            fail_count++;
          end
          if (all_resolved !== head_result.all_resolved) begin
            $error("all_resolved: expected %0d, got %0d",
                   head_result.all_resolved, all_resolved);
            fail_count++;
          end
          if (resolved_count !== head_result.resolved_count) begin
            $error("resolved_count: expected %0d, got %0d",
                   head_result.resolved_count, resolved_count);
            fail_count++;
          end
          if (first_locate !== head_result.first_locate) begin
            $error("first_locate: expected %0d, got %0d",
                   head_result.first_locate, first_locate);
            fail_count++;
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_CYCLES;
        pop          <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // The limit covers the bitmap clearing pass after reset and the long hold.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: three symbols in use, a fourth loaded but out of range.
    send_idle_pct = 8;
    recv_idle_pct = 62;
    load_symbols(3'd3, SYM_AAAA, SYM_BBBB, SYM_CCC, SYM_DDDD);
    // Writes to unused indexes must leave everything alone.
    write_reg(CFG_SPARE_5, SYM_ONES);
    write_reg(CFG_SPARE_6, SYM_ONES);
    write_reg(CFG_SPARE_7, SYM_ONES);

    queue_msg(8'd0,   TYPE_SYSTEM,    16'd0,     SYM_ZERO);
    queue_msg(8'd10,  TYPE_SYSTEM,    16'd0,     SYM_ZERO);
    queue_msg(8'd11,  TYPE_SYSTEM,    16'd0,     SYM_ZERO);
    queue_msg(8'd255, TYPE_SYSTEM,    16'hFFFF,  SYM_ONES);
    // A directory request one byte short changes nothing.
    queue_msg(8'd38,  TYPE_DIRECTORY, 16'd100,   SYM_AAAA);
    queue_msg(8'd20,  TYPE_ADD_ORDER, 16'd100,   SYM_ZERO);
    queue_msg(8'd39,  TYPE_DIRECTORY, 16'd100,   SYM_AAAA);
    queue_msg(8'd39,  TYPE_DIRECTORY, 16'd100,   SYM_AAAA);
    queue_msg(8'd36,  TYPE_ADD_ORDER, 16'd100,   SYM_ZERO);
    queue_msg(8'd255, TYPE_DIRECTORY, 16'hFFFF,  SYM_BBBB);
    queue_msg(8'd50,  TYPE_DIRECTORY, 16'd0,     SYM_CCC);
    queue_msg(8'd39,  TYPE_DIRECTORY, 16'd5,     SYM_DDDD);
    queue_msg(8'd39,  TYPE_DIRECTORY, 16'd6,     SYM_ZERO);
    queue_msg(8'd39,  TYPE_DIRECTORY, 16'd200,   SYM_AAAA);
    queue_msg(8'd11,  TYPE_LOW,       16'hFFFF,  SYM_ONES);
    queue_msg(8'd255, TYPE_HIGH,      16'd0,     SYM_ZERO);
    queue_msg(8'd11,  TYPE_ADD_ORDER, 16'd1,     SYM_ZERO);
    queue_msg(8'd39,  TYPE_DIRECTORY, 16'd100,   SYM_BBBB);
    queue_msg(8'd10,  TYPE_DIRECTORY, 16'd300,   SYM_AAAA);
    queue_msg(8'd10,  TYPE_ADD_ORDER, 16'd100,   SYM_ZERO);
    queue_msg(8'd39,  TYPE_DIRECTORY, 16'h8000,  SYM_ONES);
    wait_drained();

    // The results side stalls while requests keep coming, so the block fills.
    queue_random(280);
    hold_requests = hold_requests + 1;
    wait_drained();

    // Phase 2: count above the slot limit, all-ones and all-zero symbols.
    send_idle_pct = 62;
    recv_idle_pct = 8;
    load_symbols(3'd7, SYM_ONES, SYM_ZERO, SYM_EEE, SYM_FFF);
    queue_random(150);
    // Requests pause here until every result is back.
    wait_drained();
    queue_random(150);
    wait_drained();

    // Phase 3: no symbols in use.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_SYMBOL_COUNT, CFG_DATA_W'(3'd0));
    queue_random(40);
    wait_drained();

    // Phase 4: every slot in use.
    load_symbols(3'd4, SYM_AAAA, SYM_GGGGG, SYM_BBBB, SYM_DDDD);
    queue_random(260);
    wait_drained();

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mfsf_pkg.sv
hw/rtl/mfsf_ram.sv
hw/rtl/mfsf_front.sv
hw/rtl/mfsf_back.sv
hw/rtl/market_feed_symbol_filter.sv
verif/tb_market_feed_symbol_filter.sv
